### rtl/gfb_pkg.sv
// Shared types and constants for the GFB admission control block.
// Holds the request, response and configuration words and the sequencer states.
// No dependencies.
package gfb_pkg;

   localparam int UTIL_W   = 20;
   localparam int TOTAL_W  = 24;
   localparam int PROC_W   = 7;
   localparam int STATUS_W = 3;
   localparam int OP_W     = 2;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_ADMIT   = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
   localparam logic [OP_W-1:0] OP_READMIT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVER_TGT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER_CAP   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH   = 3'd4;

   localparam logic [REG_IDX_W-1:0] REG_SCALE  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_TARGET = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_PROC   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [UTIL_W-1:0] raw_util;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                admitted;
      logic [TOTAL_W-1:0]  total_util;
      logic [UTIL_W-1:0]   max_util;
   } rsp_type;

   typedef struct packed {
      logic [UTIL_W-1:0] scale_factor;
      logic [UTIL_W-1:0] target_util;
      logic [PROC_W-1:0] cpu_count;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCALE,
      S_SAT,
      S_GFB_MUL,
      S_GFB_CHK,
      S_APPEND,
      S_SCAN,
      S_SCAN_TAIL,
      S_REMOVE_END,
      S_RESP
   } state_type;

endpackage

### rtl/gfb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module gfb_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/gfb_csr.sv
// Configuration registers of the admission block behind an APB-style port.
// Depends on gfb_pkg for the configuration word and register indexes.
module gfb_csr
   import gfb_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   localparam logic [UTIL_W-1:0] ONE_Q = (FRAC_BITS >= UTIL_W) ? {UTIL_W{1'b1}} :
                                         UTIL_W'(1 << FRAC_BITS);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 wr;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (reg_idx)
            REG_SCALE:  cfg_in.scale_factor = pwdata[UTIL_W-1:0];
            REG_TARGET: cfg_in.target_util  = pwdata[UTIL_W-1:0];
            REG_PROC:   cfg_in.cpu_count    = pwdata[PROC_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SCALE:  prdata = DATA_W'(cfg_ff.scale_factor);
         REG_TARGET: prdata = DATA_W'(cfg_ff.target_util);
         REG_PROC:   prdata = DATA_W'(cfg_ff.cpu_count);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_factor <= ONE_Q;
         cfg_ff.target_util  <= ONE_Q;
         cfg_ff.cpu_count    <= PROC_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/gfb_admission_control.sv
// Top level of the GFB admission control block: sequencer, shared multiplier and task table.
// Depends on gfb_pkg, gfb_csr and gfb_ram.
//
//   channel   ports                                       handshake
//   request   start, busy, req_data                       taken when start && !busy
//   response  rsp_valid, rsp_data                         one-cycle strobe, no backpressure
//   config    psel, penable, pwrite, paddr, pwdata,       written on access cycle
//             prdata, pready
//
// An admit word steps through scaling, saturation, the capacity product and the check;
// a readmit skips the capacity product, and an unused op goes straight to the response.
// A remove word scans the filled entries through the single read port of the task table.
// One 20 by 20 multiplier is shared between scaling and the capacity product.
// Synchronous reset clears state, total, max, count and flags; the table needs no clearing.
// The response is presented for one cycle and the receiver cannot stall it.
module gfb_admission_control
   import gfb_pkg::*;
#(
   parameter int MAX_TASKS = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int AW     = $clog2(MAX_TASKS);
   localparam int CW     = $clog2(MAX_TASKS + 1);
   localparam int PROD_W = 2 * UTIL_W;
   localparam int GP_W   = UTIL_W + PROC_W;
   localparam int SUM_W  = ((GP_W > PROC_W + FRAC_BITS) ? GP_W : PROC_W + FRAC_BITS) + 2;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);

   cfg_type cfg;

   state_type           state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [UTIL_W-1:0]   util_ff, util_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [UTIL_W-1:0]   scaled_ff, scaled_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [UTIL_W-1:0]   max_ff, max_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_idx_ff, pend_idx_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       match_ff, match_in;
   logic [UTIL_W-1:0]   last_ff, last_in;
   logic [UTIL_W-1:0]   run_max_ff, run_max_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                adm_ff, adm_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [UTIL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [PROD_W-1:0]  shifted;
   logic [UTIL_W-1:0]  sat_util;
   logic [PROC_W-1:0]  m_eff, m_less;
   logic [UTIL_W-1:0]  umax;
   logic [SUM_W-1:0]   need_sum, cap_base;
   logic               over_cap;
   logic [TOTAL_W:0]   sum_wide;
   logic [TOTAL_W-1:0] total_add, total_sub;
   logic               table_full;
   logic [CW-1:0]      last_idx;
   logic               pend_last;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [UTIL_W-1:0] ram_wdata;
   logic [UTIL_W-1:0] ram_rdata;

   gfb_csr #(
      .FRAC_BITS(FRAC_BITS)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   gfb_ram #(
      .WIDTH(UTIL_W),
      .DEPTH(MAX_TASKS)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(idx_ff),
      .rdata(ram_rdata)
   );

   assign m_eff  = (cfg.cpu_count == '0) ? PROC_W'(1) : cfg.cpu_count;
   assign m_less = m_eff - PROC_W'(1);
   assign umax   = (max_ff > scaled_ff) ? max_ff : scaled_ff;

   assign mul_a = (state_ff == S_GFB_MUL) ? umax : util_ff;
   assign mul_b = (state_ff == S_GFB_MUL) ? UTIL_W'(m_less) : cfg.scale_factor;
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign shifted  = prod_ff >> FRAC_BITS;
   assign sat_util = (|shifted[PROD_W-1:UTIL_W]) ? {UTIL_W{1'b1}} : shifted[UTIL_W-1:0];

   assign need_sum = SUM_W'(total_ff) + SUM_W'(scaled_ff) + SUM_W'(prod_ff[GP_W-1:0]);
   assign cap_base = SUM_W'(m_eff) << FRAC_BITS;
   assign over_cap = need_sum > cap_base;

   assign sum_wide  = {1'b0, total_ff} + (TOTAL_W + 1)'(scaled_ff);
   assign total_add = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
   assign total_sub = (total_ff > TOTAL_W'(scaled_ff)) ?
                      (total_ff - TOTAL_W'(scaled_ff)) : '0;

   assign table_full = count_ff >= MAX_CNT;
   assign last_idx   = count_ff - CW'(1);
   assign pend_last  = CW'(pend_idx_ff) == last_idx;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      util_in      = util_ff;
      prod_in      = prod_ff;
      scaled_in    = scaled_ff;
      total_in     = total_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      match_in     = match_ff;
      last_in      = last_ff;
      run_max_in   = run_max_ff;
      status_in    = status_ff;
      adm_in       = adm_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = scaled_ff;

      if (pend_ff && (state_ff == S_SCAN || state_ff == S_SCAN_TAIL)) begin
         if (!found_ff && ram_rdata == scaled_ff) begin
            found_in = 1'b1;
            match_in = pend_idx_ff;
         end else if (ram_rdata > run_max_ff) begin
            run_max_in = ram_rdata;
         end
         if (pend_last) begin
            last_in = ram_rdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_data.op;
               util_in   = req_data.raw_util;
               status_in = ST_DONE;
               adm_in    = 1'b0;
               state_in  = S_SCALE;
            end
         end
         S_SCALE: begin
            prod_in  = mul_p;
            state_in = S_SAT;
         end
         S_SAT: begin
            scaled_in  = sat_util;
            idx_in     = '0;
            pend_in    = 1'b0;
            found_in   = 1'b0;
            run_max_in = '0;
            case (op_ff)
               OP_ADMIT:   state_in = S_GFB_MUL;
               OP_READMIT: state_in = S_APPEND;
               OP_REMOVE:  state_in = (count_ff == '0) ? S_REMOVE_END : S_SCAN;
               default:    state_in = S_RESP;
            endcase
         end
         S_GFB_MUL: begin
            prod_in  = mul_p;
            state_in = S_GFB_CHK;
         end
         S_GFB_CHK: begin
            if (scaled_ff > cfg.target_util) begin
               status_in = ST_OVER_TGT;
            end else if (over_cap) begin
               status_in = ST_OVER_CAP;
            end else if (table_full) begin
               status_in = ST_TABLE_FULL;
            end else begin
               ram_we   = 1'b1;
               total_in = total_add;
               max_in   = umax;
               count_in = count_ff + CW'(1);
               adm_in   = 1'b1;
            end
            state_in = S_RESP;
         end
         S_APPEND: begin
            if (table_full) begin
               status_in = ST_TABLE_FULL;
            end else begin
               ram_we   = 1'b1;
               total_in = total_add;
               max_in   = umax;
               count_in = count_ff + CW'(1);
               adm_in   = 1'b1;
            end
            state_in = S_RESP;
         end
         S_SCAN: begin
            pend_in     = 1'b1;
            pend_idx_in = idx_ff;
            idx_in      = idx_ff + AW'(1);
            if (CW'(idx_ff) == last_idx) begin
               state_in = S_SCAN_TAIL;
            end
         end
         S_SCAN_TAIL: begin
            pend_in  = 1'b0;
            state_in = S_REMOVE_END;
         end
         S_REMOVE_END: begin
            total_in = total_sub;
            max_in   = run_max_ff;
            if (found_ff) begin
               ram_we    = 1'b1;
               ram_waddr = match_ff;
               ram_wdata = last_ff;
               count_in  = count_ff - CW'(1);
            end else begin
               status_in = ST_NO_MATCH;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in      = 1'b1;
            rsp_in.status     = status_ff;
            rsp_in.admitted   = adm_ff;
            rsp_in.total_util = total_ff;
            rsp_in.max_util   = max_ff;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         max_ff       <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      util_ff     <= util_in;
      prod_ff     <= prod_in;
      scaled_ff   <= scaled_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      match_ff    <= match_in;
      last_ff     <= last_in;
      run_max_ff  <= run_max_in;
      status_ff   <= status_in;
      adm_ff      <= adm_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count exceeds table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CW'(1) || count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CW'(idx_ff) < count_ff))
      else $error("table scan beyond filled entries");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_admit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.admitted) |-> (rsp_data.status == ST_DONE))
      else $error("stored word reported with a failure status");
`endif

endmodule
